// ===== hw/rtl/cmee_pkg.sv =====
// ----------------------------------------------------------------------------
// cmee_pkg: shared constants for the cursor-move escape encoder
// Byte width of the output stream, the fixed bytes of the escape sequence
// and the field layout of the input beat.
// ----------------------------------------------------------------------------
package cmee_pkg;

  // Width of one output byte and of one input coordinate field.
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 32;

  // Fixed bytes of the cursor-position sequence.
  localparam logic [BYTE_W-1:0] BYTE_ESC      = 8'h1B;
  localparam logic [BYTE_W-1:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] BYTE_SEMI     = 8'h3B;
  localparam logic [BYTE_W-1:0] BYTE_FINAL    = 8'h48;
  localparam logic [BYTE_W-1:0] DIGIT_ZERO    = 8'h30;

endpackage

// ===== hw/rtl/cmee_bcd_pipe.sv =====
// ----------------------------------------------------------------------------
// cmee_bcd_pipe: pipelined binary-to-decimal converter
// Converts both coordinates to packed BCD with the shift-and-add-3 method,
// four bit steps per register stage. All stages move together on adv.
// ----------------------------------------------------------------------------
module cmee_bcd_pipe #(
  parameter int COORD_BITS = 32,
  parameter int DIG        = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] in_col,
  input  logic [COORD_BITS-1:0] in_row,
  output logic                  out_valid,
  output logic [DIG*4-1:0]      out_col_bcd,
  output logic [DIG*4-1:0]      out_row_bcd
);

  localparam int STEPS = 4;
  localparam int NST   = (COORD_BITS + STEPS - 1) / STEPS;
  localparam int PADW  = NST * STEPS;
  localparam int BCDW  = DIG * 4;

  // Per stage and per lane (0 = column, 1 = row): remaining binary bits and BCD.
  logic [NST-1:0]  vld_r;
  logic [PADW-1:0] bin_r [NST][2];
  logic [BCDW-1:0] bcd_r [NST][2];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic            src_v;
    logic [PADW-1:0] src_bin [2];
    logic [BCDW-1:0] src_bcd [2];
    logic [PADW-1:0] bin_nxt [2];
    logic [BCDW-1:0] bcd_nxt [2];

    // Stage source: the input for the first stage, the previous stage otherwise.
    if (s == 0) begin : g_first
      always_comb begin
        src_v      = in_valid;
        src_bin[0] = PADW'(in_col);
        src_bin[1] = PADW'(in_row);
        src_bcd[0] = '0;
        src_bcd[1] = '0;
      end
    end else begin : g_next
      always_comb begin
        src_v      = vld_r[s-1];
        src_bin[0] = bin_r[s-1][0];
        src_bin[1] = bin_r[s-1][1];
        src_bcd[0] = bcd_r[s-1][0];
        src_bcd[1] = bcd_r[s-1][1];
      end
    end

    // Four shift-and-add-3 steps on each lane.
    always_comb begin
      logic [PADW-1:0] bb;
      logic [BCDW-1:0] dd;
      for (int ln = 0; ln < 2; ln++) begin
        bb = src_bin[ln];
        dd = src_bcd[ln];
        for (int k = 0; k < STEPS; k++) begin
          for (int j = 0; j < DIG; j++) begin
            if (dd[j*4 +: 4] >= 4'd5) begin
              dd[j*4 +: 4] = dd[j*4 +: 4] + 4'd3;
            end
          end
          dd = {dd[BCDW-2:0], bb[PADW-1]};
          bb = {bb[PADW-2:0], 1'b0};
        end
        bin_nxt[ln] = bb;
        bcd_nxt[ln] = dd;
      end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= src_v;
      end
    end

    // Stage payload.
    always_ff @(posedge clk) begin
      if (adv) begin
        bin_r[s][0] <= bin_nxt[0];
        bin_r[s][1] <= bin_nxt[1];
        bcd_r[s][0] <= bcd_nxt[0];
        bcd_r[s][1] <= bcd_nxt[1];
      end
    end
  end

  assign out_valid   = vld_r[NST-1];
  assign out_col_bcd = bcd_r[NST-1][0];
  assign out_row_bcd = bcd_r[NST-1][1];

endmodule

// ===== hw/rtl/cmee_serializer.sv =====
// ----------------------------------------------------------------------------
// cmee_serializer: escape sequence byte serializer
// Holds one converted item and sends ESC, '[', row digits, ';', column
// digits and 'H' through a registered output, one byte per beat.
// ----------------------------------------------------------------------------
module cmee_serializer #(
  parameter int DIG = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [DIG*4-1:0]           in_col_bcd,
  input  logic [DIG*4-1:0]           in_row_bcd,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [cmee_pkg::BYTE_W-1:0] out_tdata,
  output logic                       out_tlast
);

  localparam int IW = $clog2(DIG);

  // Sequence phases.
  localparam logic [2:0] PH_ESC  = 3'd0;
  localparam logic [2:0] PH_LBR  = 3'd1;
  localparam logic [2:0] PH_ROW  = 3'd2;
  localparam logic [2:0] PH_SEMI = 3'd3;
  localparam logic [2:0] PH_COL  = 3'd4;
  localparam logic [2:0] PH_FIN  = 3'd5;

  logic                        busy_r, busy_nxt;
  logic [2:0]                  phase_r, phase_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [3:0]                  row_dig_r [DIG];
  logic [3:0]                  col_dig_r [DIG];
  logic [IW-1:0]               row_msd_r, row_msd_nxt;
  logic [IW-1:0]               col_msd_r, col_msd_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [cmee_pkg::BYTE_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                        out_tlast_r, out_tlast_nxt;
  logic                        load;
  logic                        take;

  // The output register can take a new byte when empty or being drained.
  assign load     = !out_tvalid_r || out_tready;
  assign in_ready = !busy_r || (load && phase_r == PH_FIN);
  assign take     = in_valid && in_ready;

  // Most significant nonzero digit of each incoming coordinate.
  always_comb begin
    row_msd_nxt = '0;
    col_msd_nxt = '0;
    for (int j = 0; j < DIG; j++) begin
      if (in_row_bcd[j*4 +: 4] != 4'd0) begin
        row_msd_nxt = IW'(j);
      end
      if (in_col_bcd[j*4 +: 4] != 4'd0) begin
        col_msd_nxt = IW'(j);
      end
    end
  end

  // Byte sequencer.
  always_comb begin
    busy_nxt       = busy_r;
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    if (busy_r && load) begin
      out_tvalid_nxt = 1'b1;
      out_tlast_nxt  = 1'b0;
      case (phase_r)
        PH_ESC: begin
          out_tdata_nxt = cmee_pkg::BYTE_ESC;
          phase_nxt     = PH_LBR;
        end
        PH_LBR: begin
          out_tdata_nxt = cmee_pkg::BYTE_LBRACKET;
          phase_nxt     = PH_ROW;
          idx_nxt       = row_msd_r;
        end
        PH_ROW: begin
          out_tdata_nxt = cmee_pkg::DIGIT_ZERO + cmee_pkg::BYTE_W'(row_dig_r[idx_r]);
          if (idx_r == '0) begin
            phase_nxt = PH_SEMI;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
        PH_SEMI: begin
          out_tdata_nxt = cmee_pkg::BYTE_SEMI;
          phase_nxt     = PH_COL;
          idx_nxt       = col_msd_r;
        end
        PH_COL: begin
          out_tdata_nxt = cmee_pkg::DIGIT_ZERO + cmee_pkg::BYTE_W'(col_dig_r[idx_r]);
          if (idx_r == '0) begin
            phase_nxt = PH_FIN;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
        PH_FIN: begin
          out_tdata_nxt = cmee_pkg::BYTE_FINAL;
          out_tlast_nxt = 1'b1;
          busy_nxt      = 1'b0;
        end
        default: begin
          out_tvalid_nxt = 1'b0;
          busy_nxt       = 1'b0;
        end
      endcase
    end else if (load) begin
      out_tvalid_nxt = 1'b0;
    end
    // A newly taken item starts over at ESC.
    if (take) begin
      busy_nxt  = 1'b1;
      phase_nxt = PH_ESC;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      phase_r      <= PH_ESC;
      out_tvalid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      phase_r      <= phase_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    if (take) begin
      row_msd_r <= row_msd_nxt;
      col_msd_r <= col_msd_nxt;
      for (int j = 0; j < DIG; j++) begin
        row_dig_r[j] <= in_row_bcd[j*4 +: 4];
        col_dig_r[j] <= in_col_bcd[j*4 +: 4];
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ===== hw/rtl/cursor_move_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// cursor_move_escape_encoder: cursor-position escape sequence encoder
//
//   Channel | Direction | tdata (low bit up)                 | tuser | tlast
//   in_     | slave     | column[31:0], row[63:32]           | -     | -
//   out_    | master    | out_byte[7:0]                      | -     | last
//
// Each beat in becomes ESC '[' row+1 ';' column+1 'H', 6 to 24 bytes, sent
// one byte per beat through a registered output; the next item is taken while
// the 'H' of the last one is loaded into that register.
// The path from input beat to first byte runs through an increment stage,
// the decimal converter stages and the serializer output register.
// rst_n is synchronous and clears only valid and sequencer state.
// The pipeline moves as a whole and holds every stage while its last stage
// holds an item that the serializer cannot take yet, so no beat is lost or
// repeated.
// ----------------------------------------------------------------------------
module cursor_move_escape_encoder #(
  parameter int COORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // column [31:0], row [63:32]
  input  logic [2*cmee_pkg::FIELD_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_byte [7:0]
  output logic [cmee_pkg::BYTE_W-1:0]       out_tdata,
  output logic                              out_tlast
);

  localparam int DIG = ((COORD_BITS * 1233) >> 12) + 1;

  logic                  adv;
  logic                  bump_v_r;
  logic [COORD_BITS-1:0] col_b_r, row_b_r;
  logic [COORD_BITS-1:0] col_raw, row_raw;
  logic [COORD_BITS-1:0] col_b_nxt, row_b_nxt;
  logic                  cv_valid;
  logic [DIG*4-1:0]      cv_col_bcd, cv_row_bcd;
  logic                  ser_ready;

  // The whole pipeline advances when its last stage is empty or drained.
  assign adv       = !cv_valid || ser_ready;
  assign in_tready = adv;

  // Increment each coordinate by one, saturating at all ones.
  assign col_raw   = in_tdata[COORD_BITS-1:0];
  assign row_raw   = in_tdata[cmee_pkg::FIELD_W +: COORD_BITS];
  assign col_b_nxt = (col_raw == '1) ? col_raw : col_raw + 1'b1;
  assign row_b_nxt = (row_raw == '1) ? row_raw : row_raw + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bump_v_r <= 1'b0;
    end else if (adv) begin
      bump_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_b_r <= col_b_nxt;
      row_b_r <= row_b_nxt;
    end
  end

  // Binary to decimal conversion.
  cmee_bcd_pipe #(
    .COORD_BITS (COORD_BITS),
    .DIG        (DIG)
  ) u_bcd_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (bump_v_r),
    .in_col      (col_b_r),
    .in_row      (row_b_r),
    .out_valid   (cv_valid),
    .out_col_bcd (cv_col_bcd),
    .out_row_bcd (cv_row_bcd)
  );

  // Byte stream generation.
  cmee_serializer #(
    .DIG (DIG)
  ) u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cv_valid),
    .in_ready   (ser_ready),
    .in_col_bcd (cv_col_bcd),
    .in_row_bcd (cv_row_bcd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/tb_cursor_move_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_cursor_move_escape_encoder: self-checking bench for the CUP encoder
// Each accepted cursor move is expanded into its expected byte sequence:
// ESC, '[', row+1, ';', column+1, 'H', with all-ones coordinates saturating.
// Every output beat is checked against the oldest pending byte. Directed
// moves come first, then random moves under three idle patterns and one long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_cursor_move_escape_encoder;

  localparam int          COORD_BITS  = 32;
  localparam logic [31:0] COORD_MASK  = 32'((64'd1 << COORD_BITS) - 64'd1);
  localparam int          RADIX       = 10;
  localparam int          LATENCY     = 3 + (COORD_BITS + 3) / 4;
  localparam int          HOLD_CYCLES = 400;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          RAND_MOVES  = 456;
  localparam int          MAX_REPORTS = 50;

  // One byte of the escape sequence together with its end-of-sequence flag.
  typedef struct packed {
    logic [cmee_pkg::BYTE_W-1:0] data;
    logic                        last;
  } seq_byte_t;

  // Scoreboard: expands accepted moves into expected bytes and checks beats.
  class cup_scoreboard;
    seq_byte_t pending[$];
    int        fail_cnt;
    int        moves;
    int        bytes_checked;
    int        saturated;
    int        ten_digit;

    function new();
      fail_cnt      = 0;
      moves         = 0;
      bytes_checked = 0;
      saturated     = 0;
      ten_digit     = 0;
    endfunction

    // Prints one mismatch line and counts it; printing stops after MAX_REPORTS lines.
    task report_mismatch(input string msg);
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS) begin
        $display("[%0t] MISMATCH: %s", $time, msg);
      end
    endtask

    function void push_byte(input logic [cmee_pkg::BYTE_W-1:0] data, input logic last);
      seq_byte_t b;
      b.data = data;
      b.last = last;
      pending = {pending, b};
    endfunction

    // The displayed coordinate is raw+1 unless the field is all ones.
    function logic [31:0] bump(input logic [31:0] raw);
      logic [31:0] v;
      v = raw & COORD_MASK;
      if (v == COORD_MASK) begin
        saturated++;
      end else begin
        v = v + 32'd1;
      end
      return v;
    endfunction

    // Queues the decimal digits of v, most significant first.
    function void push_decimal(input logic [31:0] v);
      logic [cmee_pkg::BYTE_W-1:0] digits[$];
      while (v != 0) begin
        digits.push_front(cmee_pkg::DIGIT_ZERO + cmee_pkg::BYTE_W'(v % RADIX));
        v = v / RADIX;
      end
      if (digits.size() == 10) ten_digit++;
      foreach (digits[i]) push_byte(digits[i], 1'b0);
    endfunction

    function void note_move(input logic [31:0] col, input logic [31:0] row);
      logic [31:0] col_shown;
      logic [31:0] row_shown;
      col_shown = bump(col);
      row_shown = bump(row);
      moves++;
      push_byte(cmee_pkg::BYTE_ESC, 1'b0);
      push_byte(cmee_pkg::BYTE_LBRACKET, 1'b0);
      push_decimal(row_shown);
      push_byte(cmee_pkg::BYTE_SEMI, 1'b0);
      push_decimal(col_shown);
      push_byte(cmee_pkg::BYTE_FINAL, 1'b1);
    endfunction

    task check_byte(input logic [cmee_pkg::BYTE_W-1:0] data, input logic last);
      seq_byte_t want;
      bytes_checked++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected byte 0x%02h last=%0b", data, last));
      end else begin
        want = pending.pop_front();
        if (data !== want.data) begin
          report_mismatch($sformatf("byte 0x%02h, expected 0x%02h", data, want.data));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last %0b on byte 0x%02h, expected %0b",
                                    last, data, want.last));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  cup_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycle_cnt = 0;
  logic [31:0] pow10[10];

  cursor_move_escape_encoder #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  // Run-away guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still pending",
               cycle_cnt, sb.pending.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_seen  <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output monitor: every accepted beat is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_byte(out_tdata, out_tlast);
    end
  end

  // Offers one move and returns once the block has taken it. The valid is
  // left high so that back-to-back moves need no toggle.
  task automatic send_move(input logic [31:0] col, input logic [31:0] row);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_move(col, row);
  endtask

  // Random coordinate: small values, digit-count boundaries, the saturating
  // corner and full-range values.
  function automatic logic [31:0] pick_coord();
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        return $urandom_range(99);
      end
      2: begin
        return $urandom_range(99999);
      end
      3, 4: begin
        return pow10[$urandom_range(9)] + $urandom_range(3) - 32'd2;
      end
      5: begin
        return COORD_MASK - $urandom_range(1);
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_move(pick_coord(), pick_coord());
    end
  endtask

  initial begin
    sb = new();
    pow10[0] = 32'd1;
    for (int i = 1; i < 10; i++) pow10[i] = pow10[i-1] * RADIX;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles rarely, receiver often.
    send_idle_pct = 12;
    recv_idle_pct <= 58;
    @(posedge clk);

    // Directed moves: zero, saturation, ten-digit values, digit boundaries.
    send_move(32'd0, 32'd0);
    send_move(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_move(32'hFFFF_FFFE, 32'hFFFF_FFFE);
    send_move(32'd0, 32'hFFFF_FFFF);
    send_move(32'hFFFF_FFFF, 32'd0);
    send_move(32'd8, 32'd9);
    send_move(32'd98, 32'd99);
    send_move(32'd999_999_998, 32'd999_999_999);
    send_move(32'd1_000_000_000, 32'd3_999_999_999);
    send_move(32'h8000_0000, 32'h7FFF_FFFF);
    send_move(32'h5555_5555, 32'hAAAA_AAAA);
    send_move(32'd79, 32'd23);
    send_move(32'd1, 32'd2);
    send_move(32'd9_999, 32'd99_999);
    send_random(RAND_MOVES / 3);

    // Sender idles often, receiver rarely.
    send_idle_pct = 58;
    recv_idle_pct <= 12;
    send_random(RAND_MOVES / 3);

    // No idling; a long output hold-off fills the pipeline first.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= hold_req + 1;
    send_random(RAND_MOVES - 2 * (RAND_MOVES / 3));
    in_tvalid <= 1'b0;

    // Drain, then watch for stray bytes.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.report_mismatch($sformatf("%0d bytes never arrived", sb.pending.size()));
    end

    $display("Checked %0d bytes from %0d cursor moves under three idle patterns",
             sb.bytes_checked, sb.moves);
    $display("and one %0d-cycle hold-off: %0d saturated and %0d ten-digit coordinates.",
             HOLD_CYCLES, sb.saturated, sb.ten_digit);
    if (sb.fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cmee_pkg.sv
hw/rtl/cmee_bcd_pipe.sv
hw/rtl/cmee_serializer.sv
hw/rtl/cursor_move_escape_encoder.sv
test/tb_cursor_move_escape_encoder.sv
